// ===== sv/nsc_pkg.sv =====
// Shared types, codes and helper functions for the NMEA sentence checker.
package nsc_pkg;

    // Character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // Accepted five-letter headers
    localparam logic [39:0] HDR_ZDA = "GPZDA";
    localparam logic [39:0] HDR_GGA = "GPGGA";
    localparam logic [39:0] HDR_RMC = "GPRMC";

    // Header position counts (dollar counts as one)
    localparam logic [7:0] CNT_HDR_LAST  = 8'd6;
    localparam logic [7:0] CNT_HDR_COMMA = 8'd7;

    // Reset limits
    localparam logic [7:0] LONG_LIMIT_RST = 8'd90;
    localparam logic [7:0] DATE_LIMIT_RST = 8'd50;

    // Register indexes on the configuration port
    localparam logic REG_LONG_LIMIT = 1'b0;
    localparam logic REG_DATE_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ZDA  = 2'd1,
        KIND_GGA  = 2'd2,
        KIND_RMC  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        V_OK       = 2'd0,
        V_MISMATCH = 2'd1,
        V_LONG     = 2'd2,
        V_REJECT   = 2'd3
    } t_verdict;

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_BODY   = 5'b00100,
        PH_HEX1   = 5'b01000,
        PH_HEX2   = 5'b10000
    } t_phase;

    // One result transaction
    typedef struct packed {
        t_kind      kind;
        t_verdict   verdict;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
        logic [7:0] length;
    } t_result;

    function automatic t_kind header_kind(input logic [39:0] hdr);
        t_kind k;
        k = KIND_NONE;
        if (hdr == HDR_ZDA) k = KIND_ZDA;
        else if (hdr == HDR_GGA) k = KIND_GGA;
        else if (hdr == HDR_RMC) k = KIND_RMC;
        return k;
    endfunction

    // Bit 4 flags a character that is not a hex digit; low nibble is the value
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b1_0000;
        if (c >= "0" && c <= "9") r = {1'b0, 4'(c - "0")};
        else if (c >= "A" && c <= "F") r = {1'b0, 4'(c - "A" + 8'd10)};
        else if (c >= "a" && c <= "f") r = {1'b0, 4'(c - "a" + 8'd10)};
        return r;
    endfunction

endpackage

// ===== sv/nmea_sentence_checker.sv =====
// Top level of the NMEA 0183 sentence checksum checker.
//
//  Channel   Direction  Handshake                 Payload
//  rx        in         i_rx_valid / o_rx_stall   i_rx_byte
//  res       out        o_res_valid / i_res_stall o_sentence_kind, o_verdict,
//                                                 o_computed_sum, o_received_sum,
//                                                 o_sentence_length
//  cfg       in         APB psel/penable/pready   paddr, pwdata, prdata
//
// One character per cycle while o_rx_stall is low. A character is parsed while
// it sits in the input register, once the output buffer is not full; any result it
// ends is registered into the output buffer at the next edge.
// A two-entry output buffer keeps input flowing while a result waits; input
// stalls only when both entries are held. Synchronous reset returns the parser
// to hunting for a dollar sign and sets the limits to 90/50.
module nmea_sentence_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [1:0]  o_sentence_kind,
    output logic [1:0]  o_verdict,
    output logic [7:0]  o_computed_sum,
    output logic [7:0]  o_received_sum,
    output logic [7:0]  o_sentence_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nsc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_full;
    logic       w_proc;
    logic       w_emit;
    t_result    w_result;
    t_result    w_out;
    logic [7:0] w_long_limit;
    logic [7:0] w_date_limit;

    assign w_proc     = r_in_valid & ~w_full;
    assign o_rx_stall = r_in_valid & w_full;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx_valid && !o_rx_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && !o_rx_stall) r_in_byte <= i_rx_byte;
    end

    nsc_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_long_limit (w_long_limit),
        .o_date_limit (w_date_limit)
    );

    nsc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_proc),
        .i_byte       (r_in_byte),
        .i_long_limit (w_long_limit),
        .i_date_limit (w_date_limit),
        .o_emit       (w_emit),
        .o_result     (w_result)
    );

    nsc_out_queue u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_emit),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_res_valid),
        .i_stall (i_res_stall),
        .o_data  (w_out)
    );

    assign o_sentence_kind   = w_out.kind;
    assign o_verdict         = w_out.verdict;
    assign o_computed_sum    = w_out.computed_sum;
    assign o_received_sum    = w_out.received_sum;
    assign o_sentence_length = w_out.length;

endmodule

// ===== sv/nsc_cfg.sv =====
// APB register file holding the two sentence length limits.
module nsc_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_long_limit,
    output logic [7:0]  o_date_limit
);
    import nsc_pkg::*;

    logic       w_wr;
    logic [7:0] r_long_limit;
    logic [7:0] r_date_limit;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_limit <= LONG_LIMIT_RST;
            r_date_limit <= DATE_LIMIT_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_LONG_LIMIT: r_long_limit <= pwdata[7:0];
                REG_DATE_LIMIT: r_date_limit <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (paddr[2])
            REG_LONG_LIMIT: prdata = {24'd0, r_long_limit};
            REG_DATE_LIMIT: prdata = {24'd0, r_date_limit};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_long_limit = r_long_limit;
    assign o_date_limit = r_date_limit;

endmodule

// ===== sv/nsc_parser.sv =====
// Per-character sentence parser: header match, XOR, length check, hex compare.
module nsc_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_long_limit,
    input  logic [7:0]       i_date_limit,
    output logic             o_emit,
    output nsc_pkg::t_result o_result
);
    import nsc_pkg::*;

    t_phase      r_phase, n_phase;
    logic [39:0] r_shift, n_shift;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_hex, n_hex;
    logic        r_bad, n_bad;
    t_kind       r_kind, n_kind;

    logic [7:0]  w_limit;
    logic [8:0]  w_next;
    logic        w_too_long;
    logic [4:0]  w_nib;

    assign w_limit    = (r_kind == KIND_ZDA) ? i_date_limit : i_long_limit;
    assign w_next     = {1'b0, r_count} + 9'd1;
    assign w_too_long = w_next > {1'b0, w_limit};
    assign w_nib      = hex_nibble(i_byte);

    // Next state and result for one character
    always_comb begin
        n_phase  = r_phase;
        n_shift  = r_shift;
        n_xor    = r_xor;
        n_count  = r_count;
        n_hex    = r_hex;
        n_bad    = r_bad;
        n_kind   = r_kind;
        o_emit   = 1'b0;
        o_result = '{kind: r_kind, verdict: V_OK, computed_sum: r_xor,
                     received_sum: 8'd0, length: r_count};
        if (i_valid) begin
            unique case (r_phase) inside
                PH_HUNT: begin
                    if (i_byte == CH_DOLLAR) begin
                        n_phase = PH_HEADER;
                        n_count = 8'd1;
                        n_xor   = 8'd0;
                        n_shift = 40'd0;
                        n_hex   = 8'd0;
                        n_bad   = 1'b0;
                        n_kind  = KIND_NONE;
                    end
                end
                PH_HEADER: begin
                    n_count = r_count + 8'd1;
                    n_xor   = r_xor ^ i_byte;
                    if (n_count <= CNT_HDR_LAST) begin
                        n_shift = {r_shift[31:0], i_byte};
                        if (n_count == CNT_HDR_LAST) n_kind = header_kind(n_shift);
                    end else if (n_count == CNT_HDR_COMMA) begin
                        if (i_byte != CH_COMMA) n_bad = 1'b1;
                    end else if (r_kind == KIND_NONE || r_bad || i_byte == CH_COMMA) begin
                        // Header rejected: report with this character counted
                        n_phase  = PH_HUNT;
                        o_emit   = 1'b1;
                        o_result = '{kind: r_kind, verdict: V_REJECT, computed_sum: n_xor,
                                     received_sum: 8'd0, length: n_count};
                    end else begin
                        n_bad   = 1'b0;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY, PH_HEX1, PH_HEX2: begin
                    if (w_too_long) begin
                        // Over the limit: character is dropped
                        n_phase  = PH_HUNT;
                        o_emit   = 1'b1;
                        o_result.verdict = V_LONG;
                    end else begin
                        n_count = w_next[7:0];
                        if (r_phase == PH_BODY) begin
                            if (i_byte == CH_STAR) n_phase = PH_HEX1;
                            else n_xor = r_xor ^ i_byte;
                        end else if (r_phase == PH_HEX1) begin
                            n_hex   = {w_nib[3:0], 4'd0};
                            n_bad   = r_bad | w_nib[4];
                            n_phase = PH_HEX2;
                        end else begin
                            n_hex   = {r_hex[7:4], w_nib[3:0]};
                            n_bad   = r_bad | w_nib[4];
                            n_phase = PH_HUNT;
                            o_emit  = 1'b1;
                            o_result = '{kind: r_kind,
                                         verdict: (n_bad || n_hex != r_xor) ?
                                                  V_MISMATCH : V_OK,
                                         computed_sum: r_xor,
                                         received_sum: n_hex,
                                         length: n_count};
                        end
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    // Phase is control state; the rest is loaded on each dollar
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_xor   <= n_xor;
        r_count <= n_count;
        r_hex   <= n_hex;
        r_bad   <= n_bad;
        r_kind  <= n_kind;
    end

endmodule

// ===== sv/nsc_out_queue.sv =====
// Two-entry result buffer: output register plus skid entry.
module nsc_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  nsc_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output nsc_pkg::t_result o_data
);
    import nsc_pkg::*;

    logic    r_head_valid;
    logic    r_skid_valid;
    t_result r_head;
    t_result r_skid;
    logic    w_pop;

    assign w_pop   = r_head_valid & ~i_stall;
    assign o_full  = r_head_valid & r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_data  = r_head;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_head_valid <= r_skid_valid | i_push;
                r_skid_valid <= r_skid_valid & i_push;
            end else if (i_push) begin
                r_head_valid <= 1'b1;
                r_skid_valid <= r_head_valid;
            end
        end
    end

    // Payload moves
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_head <= r_skid_valid ? r_skid : i_data;
            if (r_skid_valid) r_skid <= i_data;
        end else if (i_push) begin
            if (!r_head_valid) r_head <= i_data;
            else r_skid <= i_data;
        end
    end

endmodule

// ===== sv/nsc_checker.sv =====
// Port-level assertions for the sentence checker, bound to the top level.
module nsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_res_valid,
    input logic       i_res_stall,
    input logic [1:0] o_sentence_kind,
    input logic [1:0] o_verdict,
    input logic [7:0] o_computed_sum,
    input logic [7:0] o_received_sum,
    input logic [7:0] o_sentence_length
);
    import nsc_pkg::*;

    // A stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_stall) |=> (o_res_valid && $stable(o_verdict) &&
            $stable(o_computed_sum) && $stable(o_received_sum) &&
            $stable(o_sentence_length) && $stable(o_sentence_kind)))
        else $error("result changed while stalled");

    // Aborted sentences carry no received checksum
    a_abort_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_verdict == V_LONG || o_verdict == V_REJECT)) |->
            (o_received_sum == 8'd0))
        else $error("aborted sentence with nonzero received checksum");

    // Header is judged on the eighth character
    a_reject_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_verdict == V_REJECT) |-> (o_sentence_length == 8'd8))
        else $error("header reject with wrong length");

    // An ok verdict means the sums agree and the kind is known
    a_ok_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_verdict == V_OK) |->
            (o_computed_sum == o_received_sum && o_sentence_kind != KIND_NONE))
        else $error("ok verdict with mismatched sums or unknown kind");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_res_valid       (o_res_valid),
    .i_res_stall       (i_res_stall),
    .o_sentence_kind   (o_sentence_kind),
    .o_verdict         (o_verdict),
    .o_computed_sum    (o_computed_sum),
    .o_received_sum    (o_received_sum),
    .o_sentence_length (o_sentence_length)
);
